// ===== sv/olt_pkg.sv =====
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and codes for the ordered list table engine: operation codes,
// status codes, result field widths and the control state type.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int INVAL_W  = 32;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_FIND,
        S_OUT
    } t_state;

endpackage

// ===== sv/ordered_list_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_table_engine_unit
// Ordered list of values held in a RAM with a count of entries in use:
// append, delete at position with compaction, find first match, clear.
// ----------------------------------------------------------------------------
// One item is worked at a time. Find walks the list through the RAM read
// port, one entry per cycle, and stops early when it hits. Delete moves
// every later entry down one place by a read and a write per cycle. The
// next item is taken while a finished result waits in the output register.
// Values are stored and compared as their low VALUE_WIDTH bits
// (sign-extended from 32 when VALUE_WIDTH is wider).
module ordered_list_table_engine_unit
    import olt_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic signed [INVAL_W-1:0]  i_value,
    input  logic [POS_W-1:0]           i_position,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [POS_W-1:0]           o_found_position,
    output logic [COUNT_W-1:0]         o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]          r_wr_ptr, n_wr_ptr;
    logic                   r_pend, n_pend;
    logic [AW-1:0]          r_cmp_idx, n_cmp_idx;
    logic [VALUE_WIDTH-1:0] r_key, n_key;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [AW-1:0]          r_found, n_found;
    logic                   r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]    r_out_status, n_out_status;
    logic [POS_W-1:0]       r_out_found, n_out_found;
    logic [COUNT_W-1:0]     r_out_count, n_out_count;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [VALUE_WIDTH-1:0] w_rdata;
    logic [VALUE_WIDTH-1:0] w_val;
    logic                   w_more;

    assign w_val  = VALUE_WIDTH'(i_value);
    assign w_more = (r_rd_ptr < r_count);

    olt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_pend       = r_pend;
        n_cmp_idx    = r_cmp_idx;
        n_key        = r_key;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = r_wr_ptr[AW-1:0];
        w_wdata      = w_rdata;
        o_ready      = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_found = '0;
                    n_pend  = 1'b0;
                    case (i_mode)
                        MODE_APPEND: begin
                            n_state = S_OUT;
                            if (r_count >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we     = 1'b1;
                                w_waddr  = r_count[AW-1:0];
                                w_wdata  = w_val;
                                n_count  = r_count + 1'b1;
                                n_status = ST_OK;
                            end
                        end
                        MODE_DELETE: begin
                            if (32'(i_position) >= 32'(r_count)) begin
                                n_status = ST_BADPOS;
                                n_state  = S_OUT;
                            end else begin
                                n_wr_ptr = CW'(i_position);
                                n_rd_ptr = CW'(i_position) + 1'b1;
                                n_state  = S_DEL;
                            end
                        end
                        MODE_FIND: begin
                            n_key    = w_val;
                            n_rd_ptr = '0;
                            n_state  = S_FIND;
                        end
                        default: begin
                            n_count  = '0;
                            n_status = ST_OK;
                            n_state  = S_OUT;
                        end
                    endcase
                end
            end
            S_DEL: begin
                // read entry i+1 this cycle, write it to entry i the next
                if (w_more) begin
                    n_rd_ptr = r_rd_ptr + 1'b1;
                    n_pend   = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    w_we     = 1'b1;
                    n_wr_ptr = r_wr_ptr + 1'b1;
                end
                if (!w_more && !r_pend) begin
                    n_count  = r_count - 1'b1;
                    n_status = ST_OK;
                    n_state  = S_OUT;
                end
            end
            S_FIND: begin
                if (r_pend && (w_rdata == r_key)) begin
                    n_pend   = 1'b0;
                    n_found  = r_cmp_idx;
                    n_status = ST_OK;
                    n_state  = S_OUT;
                end else if (w_more) begin
                    n_pend    = 1'b1;
                    n_cmp_idx = r_rd_ptr[AW-1:0];
                    n_rd_ptr  = r_rd_ptr + 1'b1;
                end else begin
                    n_pend   = 1'b0;
                    n_status = ST_NOTFOUND;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = POS_W'(r_found);
                    n_out_count  = COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr     <= n_rd_ptr;
        r_wr_ptr     <= n_wr_ptr;
        r_cmp_idx    <= n_cmp_idx;
        r_key        <= n_key;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_entry_count    = r_out_count;

endmodule

// ===== sv/olt_ram.sv =====
// ----------------------------------------------------------------------------
// olt_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module olt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
